### rtl/abd_pkg.sv
// Shared types and constants for the block average downscaler.
package abd_pkg;

  // Configuration register layout
  localparam int CFG_W     = 3;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_LOG2  = 1'b0,
    REG_BLOCK_LOG2 = 1'b1
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] SIZE_LOG2_RST  = 3'd2;
  localparam logic [CFG_W-1:0] BLOCK_LOG2_RST = 3'd1;

  // Widest position a 3-bit size register can reach
  localparam int LOG_CAP = (1 << CFG_W) - 1;
  localparam int COL_W   = LOG_CAP;

  localparam int VALUE_W = 32;
  localparam int IDX_OUT_W = 6;

  localparam int Q_DEPTH   = 4;
  localparam int OUT_DEPTH = 4;

  // One classified element on its way to the accumulator
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [COL_W-1:0]          blk_col;
    logic [IDX_OUT_W-1:0]      row;
    logic [IDX_OUT_W-1:0]      col;
    logic                      last;
    logic                      emit;
    logic [CFG_W-1:0]          blk_log2;
  } item_t;

  // One finished block average
  typedef struct packed {
    logic signed [VALUE_W-1:0] avg;
    logic [IDX_OUT_W-1:0]      row;
    logic [IDX_OUT_W-1:0]      col;
    logic                      last;
  } res_t;

endpackage

### rtl/abd_fifo.sv
// Small register FIFO used between the pipeline parts.
module abd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= in_data;
    end
  end

endmodule

### rtl/abd_front.sv
// Front end: configuration registers, raster position and block classification.
module abd_front #(
  parameter int MAX_SIDE   = 64,
  parameter int ELEM_WIDTH = 32,
  parameter int SLIM       = 6,
  parameter int POS_W      = 6
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [abd_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [abd_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [abd_pkg::VALUE_W-1:0]     in_data,
  output logic                            push,
  input  logic                            push_ready,
  output abd_pkg::item_t                  item
);

  import abd_pkg::*;

  logic [CFG_W-1:0] size_log2;
  logic [CFG_W-1:0] block_log2;
  logic [POS_W-1:0] row;
  logic [POS_W-1:0] col;

  logic [CFG_W-1:0] s_eff;
  logic [CFG_W-1:0] b_eff;
  logic [POS_W:0]   side_one;
  logic [POS_W:0]   blk_one;
  logic [POS_W-1:0] side_m1;
  logic [POS_W-1:0] bmask;
  logic             col_end;
  logic             row_end;
  logic             blk_end;

  always_comb begin
    s_eff    = (size_log2 > CFG_W'(SLIM)) ? CFG_W'(SLIM) : size_log2;
    b_eff    = (block_log2 < s_eff) ? block_log2 : s_eff;
    side_one = (POS_W + 1)'(1) << s_eff;
    blk_one  = (POS_W + 1)'(1) << b_eff;
    side_m1  = POS_W'(side_one - 1'b1);
    bmask    = POS_W'(blk_one - 1'b1);
    col_end  = (col == side_m1);
    row_end  = (row == side_m1);
    blk_end  = ((row & bmask) == bmask) && ((col & bmask) == bmask);
  end

  assign in_ready = push_ready;
  assign push     = in_valid && push_ready;

  always_comb begin
    item.value    = VALUE_W'(signed'(in_data[ELEM_WIDTH-1:0]));
    item.blk_col  = COL_W'((col >> b_eff) & POS_W'(MAX_SIDE - 1));
    item.row      = IDX_OUT_W'(row >> b_eff);
    item.col      = IDX_OUT_W'(col >> b_eff);
    item.last     = row_end && col_end;
    item.emit     = blk_end;
    item.blk_log2 = b_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2  <= SIZE_LOG2_RST;
      block_log2 <= BLOCK_LOG2_RST;
      row        <= '0;
      col        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SIZE_LOG2:  size_log2  <= cfg_wdata;
        REG_BLOCK_LOG2: block_log2 <= cfg_wdata;
      endcase
      // restart the matrix
      row <= '0;
      col <= '0;
    end else if (push) begin
      if (col_end) begin
        col <= '0;
        row <= row_end ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

endmodule

### rtl/abd_back.sv
// Back end: column sum memory, read-modify-write and average computation.
module abd_back #(
  parameter int POS_W = 6,
  parameter int SUM_W = 44
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            clr,
  input  logic            in_valid,
  input  abd_pkg::item_t  in_item,
  output logic            in_ready,
  input  logic            out_pop,
  output logic            res_valid,
  output abd_pkg::res_t   res
);

  import abd_pkg::*;

  localparam int DEPTH = 1 << POS_W;
  localparam int RES_W = $clog2(OUT_DEPTH + 1);
  localparam int SH_W  = CFG_W + 1;

  logic signed [SUM_W-1:0] sums [DEPTH];
  logic [DEPTH-1:0]        vld;

  logic [RES_W-1:0]        reserved;
  logic                    pop;
  logic [POS_W-1:0]        idx_in;

  // read stage
  logic                    a_valid;
  item_t                   a_item;
  logic [POS_W-1:0]        a_idx;
  logic signed [SUM_W-1:0] rd_q;
  logic                    rd_ok;
  logic                    fwd_hit;
  logic signed [SUM_W-1:0] fwd_sum;
  logic signed [SUM_W-1:0] base;
  logic signed [SUM_W-1:0] new_sum;
  logic signed [SUM_W-1:0] wr_sum;

  // magnitude stage
  logic                    b_valid;
  logic signed [SUM_W-1:0] b_sum;
  logic [SH_W-1:0]         b_sh;
  logic [IDX_OUT_W-1:0]    b_row;
  logic [IDX_OUT_W-1:0]    b_col;
  logic                    b_last;
  logic                    b_neg;
  logic [SUM_W-1:0]        b_mag;
  logic [VALUE_W-1:0]      b_q;

  // sign stage
  logic                    c_valid;
  logic [VALUE_W-1:0]      c_q;
  logic                    c_neg;
  logic [IDX_OUT_W-1:0]    c_row;
  logic [IDX_OUT_W-1:0]    c_col;
  logic                    c_last;

  assign idx_in = in_item.blk_col[POS_W-1:0];
  assign a_idx  = a_item.blk_col[POS_W-1:0];

  // take a block end only with an output slot reserved for it
  assign pop = in_valid &&
               (!in_item.emit || (reserved < RES_W'(OUT_DEPTH)) || out_pop);
  assign in_ready = pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved <= '0;
    end else if ((pop && in_item.emit) && !out_pop) begin
      reserved <= reserved + 1'b1;
    end else if (!(pop && in_item.emit) && out_pop) begin
      reserved <= reserved - 1'b1;
    end
  end

  always_comb begin
    base    = fwd_hit ? fwd_sum : (rd_ok ? rd_q : '0);
    new_sum = base + SUM_W'(a_item.value);
    wr_sum  = a_item.emit ? '0 : new_sum;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_q <= sums[idx_in];
    end
    if (a_valid) begin
      sums[a_idx] <= wr_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld <= '0;
    end else if (a_valid) begin
      vld[a_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      a_valid <= pop;
      if (pop) begin
        // the write from the read stage lands on the same edge as this read
        fwd_hit <= a_valid && (a_idx == idx_in);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_item  <= in_item;
      rd_ok   <= vld[idx_in];
      fwd_sum <= wr_sum;
    end
  end

  always_comb begin
    b_neg = b_sum[SUM_W-1];
    b_mag = b_neg ? SUM_W'(-b_sum) : SUM_W'(b_sum);
    b_q   = VALUE_W'(b_mag >> b_sh);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      b_valid <= a_valid && a_item.emit;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    b_sum  <= new_sum;
    b_sh   <= {a_item.blk_log2, 1'b0};
    b_row  <= a_item.row;
    b_col  <= a_item.col;
    b_last <= a_item.last;
    c_q    <= b_q;
    c_neg  <= b_neg;
    c_row  <= b_row;
    c_col  <= b_col;
    c_last <= b_last;
  end

  assign res_valid = c_valid;

  always_comb begin
    res.avg  = c_neg ? signed'(-c_q) : signed'(c_q);
    res.row  = c_row;
    res.col  = c_col;
    res.last = c_last;
  end

endmodule

### rtl/block_average_downscale_top.sv
// Top level of the block average downscaler.
//
//   Channel   Direction  Signals                      Word
//   s_*       in         s_tvalid s_tready s_tdata    one matrix element
//   m_*       out        m_tvalid m_tready m_tdata    one block average
//                        m_tlast
//   cfg_*     in         cfg_we cfg_idx cfg_wdata     register write
//
// Takes one element per cycle while the output side keeps up; a block average
// follows its last element through the front queue, memory read, add,
// magnitude shift, sign and output queue.
// The column sum memory allows one read and one write per cycle, which sets
// the one element per cycle figure.
// Reset restores the registers, restarts the matrix and clears the sum valid
// bits at once; there is no clearing pass.
// With m_tready low the output queue fills, then the element queue, then
// s_tready drops.
module block_average_downscale_top #(
  parameter int MAX_SIDE   = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [31:0]                   s_tdata,   // [31:0] elem_value
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [47:0]                   m_tdata,   // [31:0] avg_value, [37:32] out_row,
                                                   // [43:38] out_col, [47:44] zero
  output logic                          m_tlast,   // last_block
  input  logic                          cfg_we,
  input  logic [abd_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [abd_pkg::CFG_W-1:0]     cfg_wdata
);

  import abd_pkg::*;

  localparam int SIDE_LOG = $clog2(MAX_SIDE + 1) - 1;
  localparam int SLIM     = (SIDE_LOG < LOG_CAP) ? SIDE_LOG : LOG_CAP;
  localparam int POS_W    = (SLIM > 0) ? SLIM : 1;
  localparam int SUM_W    = ELEM_WIDTH + 2 * SLIM;
  localparam int ITEM_W   = $bits(item_t);
  localparam int RES_W    = $bits(res_t);

  logic              fq_push;
  logic              fq_ready;
  item_t             fq_item;
  logic              fq_out_valid;
  logic [ITEM_W-1:0] fq_out_data;
  item_t             bk_item;
  logic              bk_pop;
  logic              res_push;
  res_t              res;
  logic              oq_ready;
  logic [RES_W-1:0]  oq_data;
  res_t              oq_res;
  logic              out_pop;

  abd_front #(
    .MAX_SIDE   (MAX_SIDE),
    .ELEM_WIDTH (ELEM_WIDTH),
    .SLIM       (SLIM),
    .POS_W      (POS_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_data    (s_tdata),
    .push       (fq_push),
    .push_ready (fq_ready),
    .item       (fq_item)
  );

  abd_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (Q_DEPTH)
  ) u_item_q (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_push),
    .in_ready  (fq_ready),
    .in_data   (fq_item),
    .out_valid (fq_out_valid),
    .out_ready (bk_pop),
    .out_data  (fq_out_data)
  );

  assign bk_item = item_t'(fq_out_data);

  abd_back #(
    .POS_W (POS_W),
    .SUM_W (SUM_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .clr       (cfg_we),
    .in_valid  (fq_out_valid),
    .in_item   (bk_item),
    .in_ready  (bk_pop),
    .out_pop   (out_pop),
    .res_valid (res_push),
    .res       (res)
  );

  abd_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_push),
    .in_ready  (oq_ready),
    .in_data   (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (oq_data)
  );

  assign oq_res  = res_t'(oq_data);
  assign out_pop = m_tvalid && m_tready;
  assign m_tdata = {4'b0000, oq_res.col, oq_res.row, oq_res.avg};
  assign m_tlast = oq_res.last;

  // a finished average always finds a reserved slot
  a_out_slot: assert property (@(posedge clk) disable iff (rst)
    res_push |-> oq_ready)
    else $error("block average pushed into a full output queue");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    bk_pop |-> fq_out_valid)
    else $error("back end took a word from an empty element queue");

  a_emit_follow: assert property (@(posedge clk) disable iff (rst)
    bk_pop && bk_item.emit |-> ##3 res_push)
    else $error("block end did not produce an average three cycles on");

endmodule

### verif/tb_block_average_downscale_top.sv
// Self-checking testbench for the block average downscaler top level.
`timescale 1ns / 100ps

module tb_block_average_downscale_top;
  import abd_pkg::*;

  localparam int MAX_SIDE     = 64;
  localparam int SIDE_LOG_MAX = $clog2(MAX_SIDE);
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_CYCLES = 12;

  typedef enum int {MIX_VALUES, NEAR_MIN, NEAR_MAX} elem_mix_t;

  // Running prediction of block averages and the queue of those still due
  class avg_scoreboard;
    logic [CFG_W-1:0] size_reg;
    logic [CFG_W-1:0] block_reg;
    longint           band_sum[MAX_SIDE];
    int unsigned      row_pos;
    int unsigned      col_pos;
    res_t             due_avgs[$];
    int               errors;

    function new();
      size_reg  = SIZE_LOG2_RST;
      block_reg = BLOCK_LOG2_RST;
      errors    = 0;
      restart_matrix();
    endfunction

    function void restart_matrix();
      foreach (band_sum[i]) band_sum[i] = 0;
      row_pos = 0;
      col_pos = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_SIZE_LOG2:  size_reg  = val;
        REG_BLOCK_LOG2: block_reg = val;
        default: ;
      endcase
      restart_matrix();
    endfunction

    function void note_element(logic [31:0] elem);
      int unsigned s_log, b_log, side, bmask, row, col, bcol;
      longint      sum, q;
      res_t        r;
      s_log = (size_reg > SIDE_LOG_MAX) ? SIDE_LOG_MAX : size_reg;
      b_log = (block_reg < s_log) ? block_reg : s_log;
      side  = 1 << s_log;
      bmask = (1 << b_log) - 1;
      row   = row_pos & (side - 1);
      col   = col_pos & (side - 1);
      bcol  = (col >> b_log) & (MAX_SIDE - 1);
      band_sum[bcol] += longint'($signed(elem));
      if ((row & bmask) == bmask && (col & bmask) == bmask) begin
        sum = band_sum[bcol];
        // truncate toward zero: shift the magnitude, then restore the sign
        if (sum < 0) q = -((-sum) >>> (2 * b_log));
        else q = sum >>> (2 * b_log);
        r.avg  = q[31:0];
        r.row  = IDX_OUT_W'(row >> b_log);
        r.col  = IDX_OUT_W'(col >> b_log);
        r.last = (row == side - 1) && (col == side - 1);
        due_avgs.push_back(r);
        band_sum[bcol] = 0;
      end
      if (col == side - 1) begin
        col_pos = 0;
        row_pos = (row == side - 1) ? 0 : row + 1;
      end else begin
        col_pos = col + 1;
        row_pos = row;
      end
    endfunction

    function void compare(string field, longint want, longint got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_block(logic [47:0] word, logic last);
      res_t want;
      if (due_avgs.size() == 0) begin
        $display("%0t: unexpected block average, expected none, actual avg %0d row %0d col %0d",
                 $time, $signed(word[31:0]), word[37:32], word[43:38]);
        errors++;
        return;
      end
      want = due_avgs.pop_front();
      compare("avg_value", $signed(want.avg), $signed(word[31:0]));
      compare("out_row", want.row, word[37:32]);
      compare("out_col", want.col, word[43:38]);
      compare("last_block", want.last, last);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [31:0]          s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [47:0]          m_tdata;
  logic                 m_tlast;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_SIZE_LOG2;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  avg_scoreboard sb = new();

  int tx_idle_pct = 23;
  int rx_idle_pct = 65;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycles = 0;

  block_average_downscale_top #(
    .MAX_SIDE(MAX_SIDE),
    .ELEM_WIDTH(32)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left   <= 300;
      m_tready    <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_element(s_tdata);
      if (m_tvalid && m_tready) sb.check_block(m_tdata, m_tlast);
    end
  end

  task automatic send_elem(input logic [31:0] elem);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= elem;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.due_avgs.size() != 0);
  endtask

  // Let words that cause no average clear the pipeline, then reconfigure
  task automatic configure(input logic [CFG_W-1:0] size_log2, input logic [CFG_W-1:0] block_log2);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_SIZE_LOG2;
    cfg_wdata <= size_log2;
    @(posedge clk);
    sb.write_reg(REG_SIZE_LOG2, size_log2);
    cfg_idx   <= REG_BLOCK_LOG2;
    cfg_wdata <= block_log2;
    @(posedge clk);
    sb.write_reg(REG_BLOCK_LOG2, block_log2);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] pick_elem(elem_mix_t mix);
    int unsigned r;
    r = $urandom_range(99);
    case (mix)
      NEAR_MIN: return (r < 85) ? 32'h8000_0000 : $urandom;
      NEAR_MAX: return (r < 85) ? 32'h7FFF_FFFF : $urandom;
      default: begin
        if (r < 10) return 32'h7FFF_FFFF;
        if (r < 20) return 32'h8000_0000;
        if (r < 35) return 32'($signed($urandom_range(31)) - 16);
        return $urandom;
      end
    endcase
  endfunction

  task automatic run_phase(input logic [CFG_W-1:0] size_log2, input logic [CFG_W-1:0] block_log2,
                           input int count, input elem_mix_t mix,
                           input int hold_at, input int pause_at);
    configure(size_log2, block_log2);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_requests++;
      if (i == pause_at) drain();
      send_elem(pick_elem(mix));
    end
  endtask

  initial begin
    logic [31:0] reset_matrix[$];
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings, 4x4 in 2x2 blocks: sums of full-scale elements, then negative sums
    // that must round toward zero, then the start of a second matrix
    reset_matrix = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                     32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFF9, 32'h0,
                     32'h0, 32'h0, 32'h0, 32'h0,
                     32'd5, 32'd6, 32'd7, 32'd8};
    foreach (reset_matrix[i]) send_elem(reset_matrix[i]);

    // One-element matrix, block register above the size
    configure(3'd0, 3'd7);
    send_elem(32'h7FFF_FFFF);
    send_elem(32'h8000_0000);
    send_elem(32'hFFFF_FFFD);

    tx_idle_pct = 23;
    rx_idle_pct = 65;
    run_phase(3'd3, 3'd1, 170, MIX_VALUES, -1, -1);
    run_phase(3'd1, 3'd0, 150, MIX_VALUES, 10, -1);
    run_phase(3'd7, 3'd0, 50, MIX_VALUES, -1, -1);

    tx_idle_pct = 65;
    rx_idle_pct = 23;
    run_phase(3'd4, 3'd2, 200, MIX_VALUES, -1, 100);
    run_phase(3'd7, 3'd7, 60, MIX_VALUES, -1, -1);
    run_phase(3'd4, 3'd4, 256, NEAR_MIN, -1, -1);
    run_phase(3'd4, 3'd4, 256, NEAR_MAX, -1, -1);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_phase(3'd2, 3'd3, 100, MIX_VALUES, -1, -1);
    run_phase(3'd0, 3'd0, 60, MIX_VALUES, -1, -1);
    run_phase(3'd3, 3'd2, 130, MIX_VALUES, -1, -1);

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.due_avgs.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
